[rtl/btlb_pkg.sv]
// btlb_pkg: shared types and constants of the binary time led blinker
// no dependencies; used by btlb_step and binary_time_led_blinker_core
package btlb_pkg;

	// request kinds
	localparam logic KIND_TICK  = 1'b0;
	localparam logic KIND_START = 1'b1;

	// tick counts of the blink sequence
	localparam logic [3:0] LEAD_TICKS  = 4'd4;
	localparam logic [3:0] PAUSE_TICKS = 4'd9;
	localparam logic [3:0] GAP_TICKS   = 4'd6;
	localparam logic [3:0] ONE_TICKS   = 4'd7;
	localparam logic [3:0] ZERO_TICKS  = 4'd1;
	localparam logic [3:0] WAIT_MAX    = 4'd9;

	localparam logic [4:0] HOURS_HALF = 5'd12;
	localparam logic [4:0] HOURS_DAY  = 5'd24;

	// all flags clear means idle
	typedef struct packed {
		logic first;      // first bit of the value not yet shown
		logic light;      // next action lights the current bit
		logic minute_ph;
		logic hour_ph;
	} phase_t;

	typedef struct packed {
		phase_t     phase;
		logic [3:0] wait_cnt;
		logic [5:0] shift;
		logic       led;
	} state_t;

	typedef struct packed {
		logic       led_on;
		logic       display_update;
		logic [5:0] display_value;
		logic       active;
		logic       finished;
	} result_t;

endpackage

[rtl/btlb_step.sv]
// btlb_step: next-state and result logic for one request
// depends on btlb_pkg
module btlb_step (
	input  btlb_pkg::state_t  cur,
	input  logic              mode_24h,
	input  logic              kind,
	input  logic [4:0]        hour,
	input  logic [5:0]        minute,
	output btlb_pkg::state_t  nxt,
	output btlb_pkg::result_t res
);

	logic [4:0] hour_mod;
	logic [4:0] hour_12;
	logic [4:0] hour_show;
	logic [4:0] hour_blink;
	logic [5:0] shifted;
	logic       cur_active;
	logic       upd;
	logic [5:0] dval;
	logic       fin;

	// hour modulo 12 on a 5-bit value, zero shown as twelve
	always_comb begin
		if (hour < btlb_pkg::HOURS_HALF) begin
			hour_mod = hour;
		end else if (hour < btlb_pkg::HOURS_DAY) begin
			hour_mod = hour - btlb_pkg::HOURS_HALF;
		end else begin
			hour_mod = hour - btlb_pkg::HOURS_DAY;
		end
		hour_12    = (hour_mod == 5'd0) ? btlb_pkg::HOURS_HALF : hour_mod;
		hour_show  = mode_24h ? hour : hour_12;
		// afternoon hours always blink in 12-hour form
		hour_blink = (hour_show > btlb_pkg::HOURS_HALF) ?
			(hour_show - btlb_pkg::HOURS_HALF) : hour_show;
	end

	assign cur_active = |cur.phase;
	assign shifted    = cur.phase.first ? cur.shift : (cur.shift >> 1);

	always_comb begin
		nxt  = cur;
		upd  = 1'b0;
		dval = '0;
		fin  = 1'b0;
		if (kind == btlb_pkg::KIND_START) begin
			if (!cur_active) begin
				nxt.phase    = '{first: 1'b1, light: 1'b0, minute_ph: 1'b0, hour_ph: 1'b1};
				nxt.wait_cnt = btlb_pkg::LEAD_TICKS;
				nxt.shift    = {1'b0, hour_blink};
				nxt.led      = 1'b0;
				upd          = 1'b1;
				dval         = {1'b0, hour_show};
			end
		end else if (cur_active) begin
			if (cur.wait_cnt != 4'd0) begin
				nxt.wait_cnt = cur.wait_cnt - 4'd1;
			end else if (cur.phase.light) begin
				nxt.phase.light = 1'b0;
				nxt.wait_cnt    = cur.shift[0] ? btlb_pkg::ONE_TICKS : btlb_pkg::ZERO_TICKS;
				nxt.led         = 1'b1;
			end else begin
				nxt.led   = 1'b0;
				nxt.shift = shifted;
				if (shifted != 6'd0 || cur.phase.first) begin
					nxt.phase.first = 1'b0;
					nxt.phase.light = 1'b1;
					nxt.wait_cnt    = btlb_pkg::GAP_TICKS;
				end else if (cur.phase.hour_ph) begin
					nxt.phase    = '{first: 1'b1, light: 1'b0, minute_ph: 1'b1, hour_ph: 1'b0};
					nxt.shift    = minute;
					nxt.wait_cnt = btlb_pkg::PAUSE_TICKS;
					upd          = 1'b1;
					dval         = minute;
				end else begin
					nxt.phase = '0;
					fin       = 1'b1;
				end
			end
		end
	end

	always_comb begin
		res.led_on         = nxt.led;
		res.display_update = upd;
		res.display_value  = dval;
		res.active         = |nxt.phase;
		res.finished       = fin;
	end

endmodule

[rtl/binary_time_led_blinker_core.sv]
// binary_time_led_blinker_core: top level, request register, sequence state, result register
// depends on btlb_pkg and btlb_step
//
// channel   handshake            payload
// in        in_valid / in_ready  kind, hour, minute
// out       out_valid / out_ready led_on, display_update, display_value, active, finished
// cfg       cfg_we               cfg_data (mode_24h)
//
// one request per cycle sustained while out_ready holds; each request passes through the request
// register into the result register
// the sequence state updates when a request moves into the result register
// a stalled result holds the request register; in_ready drops only when both are full
// reset clears valids, sequence state and mode_24h
module binary_time_led_blinker_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       kind,
	input  logic [4:0] hour,
	input  logic [5:0] minute,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       led_on,
	output logic       display_update,
	output logic [5:0] display_value,
	output logic       active,
	output logic       finished
);

	logic              mode_24h_q;
	logic              valid_s1;
	logic              kind_s1;
	logic [4:0]        hour_s1;
	logic [5:0]        minute_s1;
	logic              valid_s2;
	btlb_pkg::result_t res_s2;
	btlb_pkg::state_t  state_q;
	btlb_pkg::state_t  state_nxt;
	btlb_pkg::result_t res_nxt;
	logic              advance;
	logic              in_take;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_take  = in_valid && in_ready;

	btlb_step u_step (
		.cur      (state_q),
		.mode_24h (mode_24h_q),
		.kind     (kind_s1),
		.hour     (hour_s1),
		.minute   (minute_s1),
		.nxt      (state_nxt),
		.res      (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_24h_q <= 1'b0;
		end else if (cfg_we) begin
			mode_24h_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q  <= state_nxt;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			kind_s1   <= kind;
			hour_s1   <= hour;
			minute_s1 <= minute;
		end
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid      = valid_s2;
	assign led_on         = res_s2.led_on;
	assign display_update = res_s2.display_update;
	assign display_value  = res_s2.display_value;
	assign active         = res_s2.active;
	assign finished       = res_s2.finished;

	a_led_only_active: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.led |-> (|state_q.phase))
		else $error("led lit while idle");

	a_wait_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.wait_cnt <= btlb_pkg::WAIT_MAX)
		else $error("wait count out of range");

	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.finished) |-> !res_s2.active)
		else $error("finished while still active");

	a_start_goes_active: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && kind_s1 == btlb_pkg::KIND_START) |=> (|state_q.phase))
		else $error("start did not begin a sequence");

endmodule
